>>> rtl/uds_pkg.sv
// Package for the unsigned integer to digit string converter.
// Holds the channel item types, base selector codes and digit encoding.
// No dependencies.
package uds_pkg;

  // Base selector characters carried in the opcode field.
  localparam logic [7:0] SEL_HEX = 8'd104;
  localparam logic [7:0] SEL_OCT = 8'd111;
  localparam logic [7:0] SEL_BIN = 8'd98;

  // ASCII offsets for numeric and lower-case letter digits.
  localparam logic [6:0] CHAR_ZERO   = 7'd48;
  localparam logic [6:0] CHAR_LETTER = 7'd87;

  // Input item: value to convert and base selector.
  typedef struct packed {
    logic [63:0] value;
    logic [7:0]  opcode;
  } in_item_t;

  // Result item: one ASCII digit and the end-of-run flag.
  typedef struct packed {
    logic [6:0] digit_char;
    logic       last_digit;
  } out_item_t;

  // Conversion base decided by the front end.
  typedef enum logic [1:0] {
    RADIX_DEC,
    RADIX_HEX,
    RADIX_OCT,
    RADIX_BIN
  } radix_t;

  // Maps a digit value 0..15 to its lower-case ASCII character.
  function automatic logic [6:0] digit_to_char(input logic [3:0] d);
    logic [6:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {3'b000, d};
    end else begin
      c = CHAR_LETTER + {3'b000, d};
    end
    return c;
  endfunction

endpackage

>>> rtl/uds_front.sv
// Front end of the digit string converter: accepts items, masks the value
// and decodes the base selector, then holds them in a two-entry queue.
// Depends on uds_pkg.
module uds_front #(
  parameter int VALUE_BITS = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  uds_pkg::in_item_t         in_item,
  output logic                      in_stall,
  output logic                      q_valid,
  output logic [VALUE_BITS-1:0]     q_value,
  output uds_pkg::radix_t           q_radix,
  input  logic                      q_pop
);

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  logic [VALUE_BITS-1:0] q_val_r [QDEPTH];
  uds_pkg::radix_t       q_rad_r [QDEPTH];
  logic [QAW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]        count_r, count_nxt;
  uds_pkg::radix_t       radix;
  logic                  push;

  // Decode the base selector; anything unknown means decimal.
  always_comb begin
    unique case (in_item.opcode)
      uds_pkg::SEL_HEX: radix = uds_pkg::RADIX_HEX;
      uds_pkg::SEL_OCT: radix = uds_pkg::RADIX_OCT;
      uds_pkg::SEL_BIN: radix = uds_pkg::RADIX_BIN;
      default:          radix = uds_pkg::RADIX_DEC;
    endcase
  end

  assign in_stall = (count_r == QCW'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_value  = q_val_r[rd_ptr_r];
  assign q_radix  = q_rad_r[rd_ptr_r];

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage; bits above VALUE_BITS are dropped here.
  always_ff @(posedge clk) begin
    if (push) begin
      q_val_r[wr_ptr_r] <= in_item.value[VALUE_BITS-1:0];
      q_rad_r[wr_ptr_r] <= radix;
    end
  end

endmodule

>>> rtl/uds_back.sv
// Back end of the digit string converter: forms the digits (shift-add-3
// for decimal, bit fields otherwise), skips leading zeros and emits them.
// Depends on uds_pkg.
module uds_back #(
  parameter int VALUE_BITS = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  logic [VALUE_BITS-1:0]     q_value,
  input  uds_pkg::radix_t           q_radix,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output uds_pkg::out_item_t        out_item
);

  localparam int MAXD = VALUE_BITS;
  localparam int HEXN = (VALUE_BITS + 3) / 4;
  localparam int OCTN = (VALUE_BITS + 2) / 3;
  localparam int DECN = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int DW   = MAXD * 4;
  localparam int BCDW = DECN * 4;
  localparam int CW   = $clog2(MAXD + 1);
  localparam int BW   = $clog2(VALUE_BITS);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DABBLE = 4'b0010,
    ST_SKIP   = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [VALUE_BITS-1:0]   val_r, val_nxt;
  logic [BCDW-1:0]         bcd_r, bcd_nxt;
  logic [BW-1:0]           bcnt_r, bcnt_nxt;
  logic [DW-1:0]           dig_r, dig_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  uds_pkg::out_item_t      out_item_r, out_item_nxt;

  logic [DW-1:0]           pv;
  logic [DW-1:0]           load_bin, load_oct, load_hex, load_dec;
  logic [BCDW-1:0]         bcd_adj, bcd_sh;
  logic [3:0]              top_digit;
  logic                    out_free;

  // Top-aligned digit vectors for the power-of-two bases.
  always_comb begin
    pv = '0;
    pv[VALUE_BITS-1:0] = q_value;
    load_bin = '0;
    load_oct = '0;
    load_hex = '0;
    for (int i = 0; i < MAXD; i++) begin
      load_bin[4*i +: 4] = {3'b000, pv[i]};
    end
    for (int i = 0; i < OCTN; i++) begin
      load_oct[4*(MAXD-OCTN+i) +: 4] = {1'b0, pv[3*i +: 3]};
    end
    for (int i = 0; i < HEXN; i++) begin
      load_hex[4*(MAXD-HEXN+i) +: 4] = pv[4*i +: 4];
    end
  end

  // One shift-add-3 step: correct every BCD digit, then shift in a bit.
  always_comb begin
    for (int j = 0; j < DECN; j++) begin
      if (bcd_r[4*j +: 4] >= 4'd5) begin
        bcd_adj[4*j +: 4] = bcd_r[4*j +: 4] + 4'd3;
      end else begin
        bcd_adj[4*j +: 4] = bcd_r[4*j +: 4];
      end
    end
    bcd_sh = {bcd_adj[BCDW-2:0], val_r[VALUE_BITS-1]};
    load_dec = '0;
    load_dec[DW-1 -: BCDW] = bcd_sh;
  end

  assign top_digit = dig_r[DW-1 -: 4];
  assign out_free  = !out_valid_r || !out_stall;
  assign q_pop     = (state_r == ST_IDLE) && q_valid;

  // Conversion sequencer and output register.
  always_comb begin
    state_nxt     = state_r;
    val_nxt       = val_r;
    bcd_nxt       = bcd_r;
    bcnt_nxt      = bcnt_r;
    dig_nxt       = dig_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_radix)
            uds_pkg::RADIX_HEX: begin
              dig_nxt   = load_hex;
              cnt_nxt   = CW'(HEXN);
              state_nxt = ST_SKIP;
            end
            uds_pkg::RADIX_OCT: begin
              dig_nxt   = load_oct;
              cnt_nxt   = CW'(OCTN);
              state_nxt = ST_SKIP;
            end
            uds_pkg::RADIX_BIN: begin
              dig_nxt   = load_bin;
              cnt_nxt   = CW'(MAXD);
              state_nxt = ST_SKIP;
            end
            default: begin
              val_nxt   = q_value;
              bcd_nxt   = '0;
              bcnt_nxt  = BW'(VALUE_BITS - 1);
              state_nxt = ST_DABBLE;
            end
          endcase
        end
      end
      ST_DABBLE: begin
        bcd_nxt  = bcd_sh;
        val_nxt  = {val_r[VALUE_BITS-2:0], 1'b0};
        bcnt_nxt = bcnt_r - 1'b1;
        if (bcnt_r == '0) begin
          dig_nxt   = load_dec;
          cnt_nxt   = CW'(DECN);
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // Drop leading zeros, always keeping the last digit.
        if (top_digit == 4'd0 && cnt_r > CW'(1)) begin
          dig_nxt = {dig_r[DW-5:0], 4'd0};
          cnt_nxt = cnt_r - 1'b1;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.digit_char = uds_pkg::digit_to_char(top_digit);
          out_item_nxt.last_digit = (cnt_r == CW'(1));
          dig_nxt                 = {dig_r[DW-5:0], 4'd0};
          cnt_nxt                 = cnt_r - 1'b1;
          if (cnt_r == CW'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    bcd_r      <= bcd_nxt;
    bcnt_r     <= bcnt_nxt;
    dig_r      <= dig_nxt;
    cnt_r      <= cnt_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> rtl/uint_to_digit_string_core.sv
// Converts an unsigned VALUE_BITS-bit value to lower-case ASCII digits in
// base 16, 8, 2 or 10, most significant first, no leading zeros, last digit
// flagged. For a power-of-two base the value is split into N digits,
// where N is the digit count of the base for VALUE_BITS bits
// (16 hex, 22 octal, 64 binary at 64 bits); decimal takes VALUE_BITS
// shift-add-3 steps first, giving 20 BCD digits at 64 bits.
// The converter works on one item at a time; a two-entry input queue takes
// new items while it runs, and the result register drains independently.
// Depends on uds_pkg, uds_front and uds_back.
module uint_to_digit_string_core #(
  parameter int VALUE_BITS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  uds_pkg::in_item_t   in_item,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output uds_pkg::out_item_t  out_item
);

  logic                  q_valid;
  logic [VALUE_BITS-1:0] q_value;
  uds_pkg::radix_t       q_radix;
  logic                  q_pop;

  // Item intake, base decode and queue.
  uds_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .q_valid  (q_valid),
    .q_value  (q_value),
    .q_radix  (q_radix),
    .q_pop    (q_pop)
  );

  // Digit generation and output.
  uds_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_value   (q_value),
    .q_radix   (q_radix),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

>>> rtl/uds_checker.sv
// Port-level checks for the digit string converter, bound to the top level.
// Depends on uds_pkg and uint_to_digit_string_core.
module uds_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input uds_pkg::in_item_t   in_item,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input uds_pkg::out_item_t  out_item
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // Every emitted character is a lower-case digit.
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_item.digit_char >= 7'd48 && out_item.digit_char <= 7'd57) ||
                   (out_item.digit_char >= 7'd97 && out_item.digit_char <= 7'd102)))
    else $error("digit character out of range");

  // Reset empties the result register.
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Reset empties the input queue.
  a_reset_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind uint_to_digit_string_core uds_checker u_chk (.*);
